>>> rtl/core/aip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types, constants, the character-to-digit decode and a saturating position increment used by the
// ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

   localparam int AIP_MAX_LEN  = 256;
   localparam int AIP_POS_W    = $clog2(AIP_MAX_LEN + 1);
   localparam int AIP_STOP_W   = 9;
   localparam int AIP_VALUE_W  = 32;
   localparam int AIP_BASE_W   = 6;
   localparam int AIP_CHAR_W   = 8;
   localparam int AIP_REQ_W    = 8;
   localparam int AIP_RSP_W    = 48;

   localparam logic [AIP_BASE_W-1:0] BASE_AUTO = 6'd0;
   localparam logic [AIP_BASE_W-1:0] BASE_ONE  = 6'd1;
   localparam logic [AIP_BASE_W-1:0] BASE_BIN  = 6'd2;
   localparam logic [AIP_BASE_W-1:0] BASE_DEC  = 6'd10;
   localparam logic [AIP_BASE_W-1:0] BASE_HEX  = 6'd16;
   localparam logic [AIP_BASE_W-1:0] BASE_MAX  = 6'd36;

   localparam logic [AIP_CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [AIP_CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [AIP_CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [AIP_CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [AIP_CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [AIP_CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [AIP_CHAR_W-1:0] CH_UA    = 8'h41;
   localparam logic [AIP_CHAR_W-1:0] CH_UB    = 8'h42;
   localparam logic [AIP_CHAR_W-1:0] CH_UX    = 8'h58;
   localparam logic [AIP_CHAR_W-1:0] CH_UZ    = 8'h5A;
   localparam logic [AIP_CHAR_W-1:0] CH_LA    = 8'h61;
   localparam logic [AIP_CHAR_W-1:0] CH_LB    = 8'h62;
   localparam logic [AIP_CHAR_W-1:0] CH_LX    = 8'h78;
   localparam logic [AIP_CHAR_W-1:0] CH_LZ    = 8'h7A;

   typedef struct packed {
      logic                  ok;
      logic [AIP_BASE_W-1:0] val;
   } digit_type;

   typedef struct packed {
      logic                   base_error;
      logic [AIP_STOP_W-1:0]  stop_index;
      logic                   digits_found;
      logic [AIP_VALUE_W-1:0] value;
   } result_type;

   function automatic digit_type char_digit(input logic [AIP_CHAR_W-1:0] c);
      digit_type d;
      d.ok  = 1'b1;
      d.val = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d.val = AIP_BASE_W'(c - CH_ZERO);
      end else if (c >= CH_LA && c <= CH_LZ) begin
         d.val = AIP_BASE_W'(c - CH_LA + 8'd10);
      end else if (c >= CH_UA && c <= CH_UZ) begin
         d.val = AIP_BASE_W'(c - CH_UA + 8'd10);
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

   // position + 1, held at the length limit
   function automatic logic [AIP_POS_W-1:0] sat_inc(input logic [AIP_POS_W-1:0] p);
      logic [AIP_POS_W-1:0] r;
      r = (p == AIP_POS_W'(AIP_MAX_LEN)) ? p : p + AIP_POS_W'(1);
      return r;
   endfunction

endpackage

>>> rtl/core/aip_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_core
// Parse state and per-character update. One word is consumed per fire
// strobe; the result for a last word is presented combinationally.
// ----------------------------------------------------------------------------
module aip_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  logic [aip_pkg::AIP_CHAR_W-1:0]   char_in,
   input  logic                             last_in,
   input  logic [aip_pkg::AIP_BASE_W-1:0]   base_sel,
   output aip_pkg::result_type              result
);
   import aip_pkg::*;

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_PREFIX,
      PH_ZERO,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic                    neg_ff, neg_in;
   logic [AIP_BASE_W-1:0]   base_ff, base_in;
   logic [AIP_VALUE_W-1:0]  acc_ff, acc_in;
   logic                    seen_ff, seen_in;
   logic [AIP_POS_W-1:0]    pos_ff, pos_in;
   logic [AIP_POS_W-1:0]    endp_ff, endp_in;

   logic [AIP_BASE_W-1:0]   plain_base;
   logic                    may_prefix;
   logic                    prefix_pt;
   logic                    take;
   logic [AIP_BASE_W-1:0]   t_base;
   logic [AIP_VALUE_W-1:0]  t_acc;
   logic [AIP_VALUE_W+AIP_BASE_W-1:0] mac_full;
   logic [AIP_POS_W-1:0]    pos_inc;
   digit_type               dig;
   logic                    err;
   logic                    seen_fin;
   logic [AIP_VALUE_W-1:0]  val_signed;

   always_comb begin
      plain_base = (base_sel == BASE_AUTO) ? BASE_DEC : base_sel;
      may_prefix = (base_sel == BASE_AUTO) || (base_sel == BASE_HEX) || (base_sel == BASE_BIN);
      dig        = char_digit(char_in);
      pos_inc    = sat_inc(pos_ff);

      phase_in  = phase_ff;
      neg_in    = neg_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      seen_in   = seen_ff;
      endp_in   = endp_ff;
      pos_in    = pos_inc;
      prefix_pt = 1'b0;
      take      = 1'b0;
      t_base    = base_ff;
      t_acc     = acc_ff;

      unique case (phase_ff)
         PH_SPACE: begin
            if (char_in == CH_SPACE || char_in == CH_TAB) begin
               phase_in = PH_SPACE;
            end else if (char_in == CH_MINUS) begin
               neg_in   = 1'b1;
               phase_in = PH_PREFIX;
            end else if (char_in == CH_PLUS) begin
               phase_in = PH_PREFIX;
            end else begin
               prefix_pt = 1'b1;
            end
         end
         PH_PREFIX: begin
            prefix_pt = 1'b1;
         end
         PH_ZERO: begin
            if ((char_in == CH_LX || char_in == CH_UX) &&
                (base_sel == BASE_AUTO || base_sel == BASE_HEX)) begin
               base_in  = BASE_HEX;
               phase_in = PH_DIGITS;
            end else if ((char_in == CH_LB || char_in == CH_UB) &&
                         (base_sel == BASE_AUTO || base_sel == BASE_BIN)) begin
               base_in  = BASE_BIN;
               phase_in = PH_DIGITS;
            end else begin
               // pending zero turns into a plain digit
               base_in  = plain_base;
               acc_in   = '0;
               seen_in  = 1'b1;
               phase_in = PH_DIGITS;
               take     = 1'b1;
               t_base   = plain_base;
               t_acc    = '0;
            end
         end
         PH_DIGITS: begin
            take = 1'b1;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      if (prefix_pt) begin
         if (may_prefix && char_in == CH_ZERO) begin
            endp_in  = pos_inc;
            phase_in = PH_ZERO;
         end else begin
            base_in  = plain_base;
            phase_in = PH_DIGITS;
            take     = 1'b1;
            t_base   = plain_base;
         end
      end

      mac_full = (AIP_VALUE_W+AIP_BASE_W)'(t_acc) * (AIP_VALUE_W+AIP_BASE_W)'(t_base)
               + (AIP_VALUE_W+AIP_BASE_W)'(dig.val);

      if (take) begin
         if (dig.ok && dig.val < t_base) begin
            acc_in  = mac_full[AIP_VALUE_W-1:0];
            seen_in = 1'b1;
            endp_in = pos_inc;
         end else begin
            phase_in = PH_DONE;
         end
      end

      // a zero still pending at the end counts as a digit
      err        = (base_sel == BASE_ONE) || (base_sel > BASE_MAX);
      seen_fin   = seen_in || (phase_in == PH_ZERO);
      val_signed = neg_in ? (AIP_VALUE_W'(0) - acc_in) : acc_in;

      result.base_error   = err;
      result.value        = err ? '1 : val_signed;
      result.digits_found = !err && seen_fin;
      result.stop_index   = (!err && seen_fin) ? AIP_STOP_W'(endp_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && last_in)) begin
         phase_ff <= PH_SPACE;
         neg_ff   <= 1'b0;
         base_ff  <= '0;
         acc_ff   <= '0;
         seen_ff  <= 1'b0;
         pos_ff   <= '0;
         endp_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         base_ff  <= base_in;
         acc_ff   <= acc_in;
         seen_ff  <= seen_in;
         pos_ff   <= pos_in;
         endp_ff  <= endp_in;
      end
   end

endmodule

>>> rtl/core/ascii_integer_parser_top.sv
`timescale 1ns / 1ps
// Path: an accepted last word passes the input register, then the result register.
// Throughput: one word per cycle, a last word waiting out result backpressure; the
// parse state update (one 32x6 multiply-add plus selection) lies between them.
// Reset: synchronous, active high; clears parse state, base register and valids.
// ----------------------------------------------------------------------------
// ascii_integer_parser_top
// Streams characters of a string and returns the parsed signed integer
// on the word marked last.
// ----------------------------------------------------------------------------
module ascii_integer_parser_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [aip_pkg::AIP_BASE_W-1:0]   csr_wdata,   // base_select
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [aip_pkg::AIP_REQ_W-1:0]    req_tdata,   // [7:0] character
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] value, [32] digits_found, [41:33] stop_index, [42] base_error
   output logic [aip_pkg::AIP_RSP_W-1:0]    rsp_tdata
);
   import aip_pkg::*;

   logic [AIP_BASE_W-1:0]  base_ff;
   logic                   s1_valid_ff, s1_valid_in;
   logic [AIP_CHAR_W-1:0]  s1_char_ff;
   logic                   s1_last_ff;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_data_ff;
   result_type             core_result;
   logic                   out_free;
   logic                   s1_go;
   logic                   req_take;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = req_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      if (s1_go && s1_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   aip_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (s1_go),
      .char_in  (s1_char_ff),
      .last_in  (s1_last_ff),
      .base_sel (base_ff),
      .result   (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_char_ff <= req_tdata[AIP_CHAR_W-1:0];
         s1_last_ff <= req_tlast;
      end
      if (s1_go && s1_last_ff) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = AIP_RSP_W'({out_data_ff.base_error, out_data_ff.stop_index,
                                   out_data_ff.digits_found, out_data_ff.value});

endmodule

>>> rtl/core/aip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_checker
// Port-level checks on the result channel of the parser.
// ----------------------------------------------------------------------------
module aip_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [aip_pkg::AIP_RSP_W-1:0]   rsp_tdata
);
   import aip_pkg::*;

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // error result carries the fixed error pattern
   a_err_pattern: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[42] |->
         rsp_tdata[31:0] == 32'hFFFF_FFFF && !rsp_tdata[32] && rsp_tdata[41:33] == 9'd0)
      else $error("bad error result");

   // no digits, no stop index
   a_nodigit_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[32] |-> rsp_tdata[41:33] == 9'd0)
      else $error("stop index without digits");

   // a converted digit leaves a stop index between 1 and the length limit
   a_digit_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |->
         rsp_tdata[41:33] != 9'd0 && rsp_tdata[41:33] <= AIP_STOP_W'(AIP_MAX_LEN))
      else $error("stop index out of range");

endmodule

bind ascii_integer_parser_top aip_checker u_aip_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
